FILE: hw/rtl/acc_pkg.sv
// ----------------------------------------------------------------------------
// acc_pkg
// Shared types, constants and the microcode store of the accumulator machine.
// ----------------------------------------------------------------------------
package acc_pkg;

    // program memory geometry and instruction format
    localparam int MEM_DEPTH = 32;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 8;
    localparam int OPC_W     = 3;
    localparam int STEP_W    = 16;
    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    // instruction opcodes
    typedef enum logic [OPC_W-1:0] {
        OP_STA = 3'd0,
        OP_LDA = 3'd1,
        OP_BEQ = 3'd2,
        OP_NOP = 3'd3,
        OP_DEC = 3'd4,
        OP_INC = 3'd5,
        OP_JMP = 3'd6,
        OP_HLT = 3'd7
    } t_opc;

    // microcode addresses; the eight execute steps follow opcode order
    typedef enum logic [3:0] {
        U_IDLE  = 4'd0,
        U_INIT  = 4'd1,
        U_CHK   = 4'd2,
        U_FETCH = 4'd3,
        U_STA   = 4'd4,
        U_LDA   = 4'd5,
        U_BEQ   = 4'd6,
        U_NOP   = 4'd7,
        U_DEC   = 4'd8,
        U_INC   = 4'd9,
        U_JMP   = 4'd10,
        U_HLT   = 4'd11,
        U_LDW   = 4'd12,
        U_TMO   = 4'd13
    } t_upc;

    // control word fields
    typedef enum logic {
        RD_PC = 1'b0,
        RD_IR = 1'b1
    } t_rd_sel;

    typedef enum logic [2:0] {
        PC_HOLD  = 3'd0,
        PC_CLR   = 3'd1,
        PC_INC   = 3'd2,
        PC_LOAD  = 3'd3,
        PC_LOADZ = 3'd4
    } t_pc_op;

    typedef enum logic [2:0] {
        AC_HOLD = 3'd0,
        AC_CLR  = 3'd1,
        AC_INC  = 3'd2,
        AC_DEC  = 3'd3,
        AC_LOAD = 3'd4
    } t_acc_op;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_CLR  = 2'd1,
        CNT_INC  = 2'd2
    } t_cnt_op;

    typedef enum logic [1:0] {
        OUT_NONE = 2'd0,
        OUT_HALT = 2'd1,
        OUT_TMO  = 2'd2
    } t_out_op;

    typedef enum logic [1:0] {
        NX_JMP  = 2'd0,   // unconditional jump to target
        NX_GO   = 2'd1,   // jump to target when a run is started, else stay
        NX_LIM  = 2'd2,   // jump to target on step limit, else fall through
        NX_DISP = 2'd3    // dispatch on the fetched opcode
    } t_nxt;

    typedef struct packed {
        t_rd_sel rd_sel;
        logic    mem_we;
        t_pc_op  pc_op;
        t_acc_op acc_op;
        logic    ir_ld;
        t_cnt_op cnt_op;
        t_out_op out_op;
        t_nxt    nxt;
        t_upc    target;
    } t_uword;

    // microcode store
    function automatic t_uword urom(input t_upc addr);
        t_uword w;
        w = '{rd_sel: RD_PC, mem_we: 1'b0, pc_op: PC_HOLD, acc_op: AC_HOLD,
              ir_ld: 1'b0, cnt_op: CNT_HOLD, out_op: OUT_NONE,
              nxt: NX_JMP, target: U_CHK};
        case (addr)
            U_IDLE: begin
                w.nxt    = NX_GO;
                w.target = U_INIT;
            end
            U_INIT: begin
                w.pc_op  = PC_CLR;
                w.acc_op = AC_CLR;
                w.cnt_op = CNT_CLR;
            end
            U_CHK: begin
                w.nxt    = NX_LIM;
                w.target = U_TMO;
            end
            U_FETCH: begin
                w.ir_ld  = 1'b1;
                w.pc_op  = PC_INC;
                w.cnt_op = CNT_INC;
                w.nxt    = NX_DISP;
            end
            U_STA:   w.mem_we = 1'b1;
            U_LDA: begin
                w.rd_sel = RD_IR;
                w.target = U_LDW;
            end
            U_LDW:   w.acc_op = AC_LOAD;
            U_BEQ:   w.pc_op  = PC_LOADZ;
            U_NOP:   w.nxt    = NX_JMP;
            U_DEC:   w.acc_op = AC_DEC;
            U_INC:   w.acc_op = AC_INC;
            U_JMP:   w.pc_op  = PC_LOAD;
            U_HLT: begin
                w.out_op = OUT_HALT;
                w.target = U_IDLE;
            end
            U_TMO: begin
                w.out_op = OUT_TMO;
                w.target = U_IDLE;
            end
            default: w.target = U_IDLE;
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/acc_ram.sv
// ----------------------------------------------------------------------------
// acc_ram
// Generic dual-port RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module acc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/acc_useq.sv
// ----------------------------------------------------------------------------
// acc_useq
// Microcode sequencer: address register, next-address logic and control store.
// ----------------------------------------------------------------------------
module acc_useq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic                          i_lim_hit,
    input  logic [acc_pkg::OPC_W-1:0]     i_opcode,
    output acc_pkg::t_uword               o_uword,
    output logic                          o_busy
);

    import acc_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword uw;

    assign uw = urom(r_upc);

    // next microcode address
    always_comb begin
        case (uw.nxt)
            NX_JMP:  n_upc = uw.target;
            NX_GO:   n_upc = i_go ? uw.target : r_upc;
            NX_LIM:  n_upc = i_lim_hit ? uw.target : t_upc'(r_upc + 4'd1);
            NX_DISP: n_upc = t_upc'(4'(U_STA) + {1'b0, i_opcode});
            default: n_upc = U_IDLE;
        endcase
    end

    // microcode address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_uword = uw;
    assign o_busy  = (r_upc != U_IDLE);

endmodule

FILE: hw/rtl/accumulator_cpu_32byte.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_32byte
// 8-bit accumulator machine: loads 32 program bytes, then runs to HLT or limit.
// ----------------------------------------------------------------------------
// Loading: one item per cycle while o_busy is low; no result for bytes 1..31.
// The 32nd byte starts a run: a setup step, then per instruction a limit check,
// a fetch from the registered-read RAM and an execute step, with an LDA operand
// read on the same RAM port; a timeout adds a last limit check and a flag step.
// o_done strobes in the cycle after the run, with o_busy low; no receiver stall.
// Reset (synchronous, active low) clears load index, sequencer and step limit.
module accumulator_cpu_32byte (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [acc_pkg::DATA_W-1:0]   i_prog_byte,
    input  logic                         i_cfg_we,
    input  logic [acc_pkg::STEP_W-1:0]   i_cfg_wdata,
    output logic                         o_done,
    output logic [acc_pkg::DATA_W-1:0]   o_accumulator,
    output logic                         o_timed_out
);

    import acc_pkg::*;

    logic [ADDR_W-1:0]   r_load_idx;
    logic [ADDR_W-1:0]   r_pc;
    logic [DATA_W-1:0]   r_acc;
    logic [DATA_W-1:0]   r_ir;
    logic [STEP_W-1:0]   r_steps;
    logic [STEP_W-1:0]   r_step_limit;
    logic                r_done;
    logic [DATA_W-1:0]   r_acc_out;
    logic                r_timed_out;

    t_uword              uw;
    logic                busy;
    logic                accept;
    logic                go;
    logic                lim_hit;
    logic [STEP_W-1:0]   eff_limit;
    logic [DATA_W-1:0]   rdata;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ADDR_W-1:0]   ir_addr;

    assign accept  = i_start && !busy;
    assign go      = accept && (r_load_idx == ADDR_W'(MEM_DEPTH - 1));
    assign ir_addr = r_ir[ADDR_W-1:0];

    // a zero limit means the full range of the step counter
    assign eff_limit = (r_step_limit == '0) ? STEP_MAX : r_step_limit;
    assign lim_hit   = (r_steps == eff_limit);

    acc_useq u_useq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_lim_hit (lim_hit),
        .i_opcode  (rdata[DATA_W-1 -: OPC_W]),
        .o_uword   (uw),
        .o_busy    (busy)
    );

    // ram port sharing: loader while idle, microcode during a run
    always_comb begin
        if (busy) begin
            ram_we    = uw.mem_we;
            ram_waddr = ir_addr;
            ram_wdata = r_acc;
        end else begin
            ram_we    = accept;
            ram_waddr = r_load_idx;
            ram_wdata = i_prog_byte;
        end
        ram_raddr = (uw.rd_sel == RD_IR) ? ir_addr : r_pc;
    end

    acc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    // control registers: load index, step limit, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx   <= '0;
            r_step_limit <= '0;
            r_done       <= 1'b0;
        end else begin
            if (accept) begin
                r_load_idx <= r_load_idx + ADDR_W'(1);
            end
            if (i_cfg_we) begin
                r_step_limit <= i_cfg_wdata;
            end
            r_done <= (uw.out_op != OUT_NONE);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (uw.pc_op)
            PC_CLR:   r_pc <= '0;
            PC_INC:   r_pc <= r_pc + ADDR_W'(1);
            PC_LOAD:  r_pc <= ir_addr;
            PC_LOADZ: if (r_acc == '0) begin
                r_pc <= ir_addr;
            end
            default:  r_pc <= r_pc;
        endcase

        case (uw.acc_op)
            AC_CLR:  r_acc <= '0;
            AC_INC:  r_acc <= r_acc + DATA_W'(1);
            AC_DEC:  r_acc <= r_acc - DATA_W'(1);
            AC_LOAD: r_acc <= rdata;
            default: r_acc <= r_acc;
        endcase

        case (uw.cnt_op)
            CNT_CLR: r_steps <= '0;
            CNT_INC: r_steps <= r_steps + STEP_W'(1);
            default: r_steps <= r_steps;
        endcase

        if (uw.ir_ld) begin
            r_ir <= rdata;
        end

        if (uw.out_op != OUT_NONE) begin
            r_acc_out   <= r_acc;
            r_timed_out <= (uw.out_op == OUT_TMO);
        end
    end

    assign o_busy        = busy;
    assign o_done        = r_done;
    assign o_accumulator = r_acc_out;
    assign o_timed_out   = r_timed_out;

endmodule
